[src/ole_pkg.sv]
// Shared constants, request and status codes, and control types for the ordered list engine.
package ole_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int REQ_W  = 4;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 4'd3;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 4'd4;
  localparam logic [REQ_W-1:0] REQ_NTH        = 4'd5;
  localparam logic [REQ_W-1:0] REQ_MAX        = 4'd6;
  localparam logic [REQ_W-1:0] REQ_MIN        = 4'd7;
  localparam logic [REQ_W-1:0] REQ_LENGTH     = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;

  typedef struct packed {
    logic load;
    logic push;
    logic start_scan;
    logic start_nth;
    logic start_shift;
    logic issue;
    logic scanning;
    logic shifting;
    logic shrink;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_scan;
    logic is_nth;
    logic is_delete;
    logic full;
    logic empty;
    logic nth_ok;
    logic found;
    logic busy;
    logic out_free;
  } dp_stat_t;

  // Maps a position in the list to its slot in the circular buffer.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] lidx);
    logic [SUM_W-1:0] s;
    s = {{(SUM_W - IDX_W){1'b0}}, base} + {1'b0, lidx};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

[src/ordered_list_engine.sv]
// Top level of the ordered list engine, joining the controller and the datapath.
//
//   Channel   Direction  Handshake             Payload
//   request   in         in_valid / in_ready   req_type, operand
//   result    out        out_valid / out_ready status, found, result_value
//
// Pushes, length, unused codes and requests on an empty list or with a bad position go from
// decoding straight to the result; a valid nth read reads only the one entry that it names.
// Search, count, maximum and minimum sweep the memory read port once over the list.
// A delete that matches sweeps again over the entries behind the match to close the gap.
// Reset empties the list at once; a stalled result holds in the output register while
// the next request is taken, and the engine waits only when a second result is ready.
module ordered_list_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ole_pkg::REQ_W-1:0]        req_type,
  input  logic signed [ole_pkg::DATA_W-1:0] operand,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ole_pkg::STAT_W-1:0]       status,
  output logic                             found,
  output logic signed [ole_pkg::DATA_W-1:0] result_value
);
  import ole_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ole_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .operand      (operand),
    .status       (status),
    .found        (found),
    .result_value (result_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[src/ole_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module ole_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ole_pkg::dp_stat_t  stat,
  output ole_pkg::ctrl_cmd_t cmd
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_FINISH;
        if (stat.is_push && !stat.full) begin
          cmd.push = 1'b1;
        end else if (stat.is_scan && !stat.empty) begin
          cmd.start_scan = 1'b1;
          state_next = S_SCAN;
        end else if (stat.is_nth && !stat.empty && stat.nth_ok) begin
          cmd.start_nth = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        cmd.scanning = 1'b1;
        if (!stat.busy) begin
          if (stat.is_delete && stat.found) begin
            cmd.start_shift = 1'b1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.issue = 1'b1;
        cmd.shifting = 1'b1;
        if (!stat.busy) begin
          cmd.shrink = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

[src/ole_dp.sv]
// Datapath with the list memory, the read sweep, the compare logic and the result register.
module ole_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ole_pkg::REQ_W-1:0]        req_type,
  input  logic signed [ole_pkg::DATA_W-1:0] operand,
  output logic [ole_pkg::STAT_W-1:0]       status,
  output logic                             found,
  output logic signed [ole_pkg::DATA_W-1:0] result_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  ole_pkg::ctrl_cmd_t               cmd,
  output ole_pkg::dp_stat_t                stat
);
  import ole_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [REQ_W-1:0]  req_q;
  logic [DATA_W-1:0] opnd_q;
  logic              full_q;
  logic              empty_q;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  rd_end;
  logic              rd_v;
  logic [CNT_W-1:0]  rd_lidx;
  logic [DATA_W-1:0] rdata;
  logic              hit;
  logic [CNT_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  hit_cnt;
  logic [DATA_W-1:0] best;

  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  head_dec;
  logic              eq;
  logic              better;
  logic [CNT_W-1:0]  opnd_cnt;
  logic              nth_ok;
  logic [STAT_W-1:0] res_status;
  logic              res_found;
  logic [DATA_W-1:0] res_value;

  assign issue    = cmd.issue && (rd_ptr < rd_end);
  assign rd_addr  = phys(head, rd_ptr);
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign eq       = (rdata == opnd_q);
  assign better   = (req_q == REQ_MAX) ? ($signed(rdata) > $signed(best))
                                       : ($signed(rdata) < $signed(best));
  assign opnd_cnt = opnd_q[CNT_W-1:0];
  assign nth_ok   = !opnd_q[DATA_W-1] && (opnd_q != '0)
                    && (opnd_q <= {{(DATA_W - CNT_W){1'b0}}, occ});

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (req_q == REQ_PUSH_FRONT) begin
        mem[head_dec] <= opnd_q;
      end else begin
        mem[phys(head, occ)] <= opnd_q;
      end
    end else if (cmd.shifting && rd_v) begin
      mem[phys(head, rd_lidx - 1'b1)] <= rdata;
    end
    if (issue) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ <= '0;
      rd_ptr <= '0;
      rd_end <= '0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (req_q == REQ_PUSH_FRONT) begin
          head <= head_dec;
        end
        occ <= occ + 1'b1;
      end else if (cmd.shrink) begin
        occ <= occ - 1'b1;
      end
      if (cmd.start_scan) begin
        rd_ptr <= '0;
        rd_end <= occ;
      end else if (cmd.start_nth) begin
        rd_ptr <= opnd_cnt - 1'b1;
        rd_end <= opnd_cnt;
      end else if (cmd.start_shift) begin
        rd_ptr <= hit_idx + 1'b1;
        rd_end <= occ;
      end else if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      rd_v <= issue;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      opnd_q <= operand;
      full_q <= (occ == CNT_W'(DEPTH));
      empty_q <= (occ == '0);
      hit <= 1'b0;
      hit_cnt <= '0;
    end else if (cmd.scanning && rd_v) begin
      if (eq) begin
        hit <= 1'b1;
        hit_cnt <= hit_cnt + 1'b1;
        if (!hit) begin
          hit_idx <= rd_lidx;
        end
      end
      if ((rd_lidx == '0) || better) begin
        best <= rdata;
      end
    end
    if (issue) begin
      rd_lidx <= rd_ptr;
    end
    if (cmd.result_load) begin
      status <= res_status;
      found <= res_found;
      result_value <= res_value;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_found = 1'b0;
    res_value = '0;
    unique case (req_q)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full_q) begin
          res_status = ST_FULL;
        end
      end
      REQ_DELETE, REQ_SEARCH: begin
        if (empty_q) begin
          res_status = ST_EMPTY;
        end else if (hit) begin
          res_found = 1'b1;
        end else begin
          res_status = ST_MISSING;
        end
      end
      REQ_COUNT: begin
        if (empty_q) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = {{(DATA_W - CNT_W){1'b0}}, hit_cnt};
        end
      end
      REQ_NTH: begin
        if (empty_q) begin
          res_status = ST_EMPTY;
        end else if (!nth_ok) begin
          res_status = ST_RANGE;
        end else begin
          res_value = rdata;
        end
      end
      REQ_MAX, REQ_MIN: begin
        if (empty_q) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = best;
        end
      end
      REQ_LENGTH: begin
        res_value = {{(DATA_W - CNT_W){1'b0}}, occ};
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign stat.is_push   = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
  assign stat.is_scan   = (req_q == REQ_DELETE) || (req_q == REQ_SEARCH)
                          || (req_q == REQ_COUNT) || (req_q == REQ_MAX)
                          || (req_q == REQ_MIN);
  assign stat.is_nth    = (req_q == REQ_NTH);
  assign stat.is_delete = (req_q == REQ_DELETE);
  assign stat.full      = full_q;
  assign stat.empty     = empty_q;
  assign stat.nth_ok    = nth_ok;
  assign stat.found     = hit;
  assign stat.busy      = (rd_ptr < rd_end) || rd_v;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

[src/ole_checker.sv]
// Port-level checker for the ordered list engine and its bind to the top level.
module ole_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ole_pkg::STAT_W-1:0]       status,
  input logic                             found,
  input logic signed [ole_pkg::DATA_W-1:0] result_value
);
  import ole_pkg::*;

  // Only one request is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
    && $stable(result_value))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_EMPTY) || (status == ST_MISSING)
    || (status == ST_FULL) || (status == ST_RANGE))
    else $error("undefined status code");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK)
    else $error("found flagged with an error status");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (result_value == '0) && !found)
    else $error("error result carries a value");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .found        (found),
  .result_value (result_value)
);
